>>> src/fpc_pkg.sv
// shared types and constants for the frustum plane and sphere cull unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  // operation codes carried by op
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_DERIVE = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  // widths fixed by the arithmetic
  localparam int VW    = 33;   // plane component before normalising
  localparam int SQ_W  = 66;   // sum of three squared components
  localparam int LEN_W = 34;   // integer square root of that sum

  localparam logic [31:0] INT32_MAX_C = 32'h7fff_ffff;
  localparam logic [31:0] INT32_MIN_C = 32'h8000_0000;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_SQ,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT,
    S_TEST,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> src/frustum_plane_sphere_cull_unit.sv
// top level of the frustum plane extraction and sphere cull unit
// depends on fpc_pkg, fpc_mul, fpc_sqrt and fpc_div
`timescale 1ns / 1ps
`default_nettype none

// Holds a 4x4 view-projection matrix in signed fixed point (FRAC_BITS fraction
// bits, column-major, one element per op 0 item), derives the six clip planes
// on op 1 (plane 2i is row 3 minus row i, plane 2i+1 row 3 plus row i, for
// x, y, z), normalised by the integer square root of the xyz length, and on
// op 2 tests a sphere against the planes that plane_mask enables, giving one
// visible flag. One item is worked on at a time and item_stall is high until
// its last result is in the output register. The pace of a sphere test is
// set by the single shared multiplier doing three products per enabled plane.
// A plane derivation works six planes per item, paced by the bit-serial root
// (34 steps) and the bit-serial divider (one quotient bit a cycle for each of
// the four coefficients). A zero-length normal gives a zero plane with degenerate
// set. The output register lets the next step run while a result waits; the
// sequencer only holds when a second result is due and the first has not been
// taken.
module frustum_plane_sphere_cull_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [5:0]         cfg_data,
  // input items
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [1:0]         op,
  input  wire logic [3:0]         element_index,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  input  wire logic [30:0]        radius,
  // result items
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    visible,
  output logic [2:0]              plane_index,
  output logic signed [31:0]      plane_a,
  output logic signed [31:0]      plane_b,
  output logic signed [31:0]      plane_c,
  output logic signed [31:0]      plane_d,
  output logic                    degenerate,
  output logic                    last
);
  import fpc_pkg::*;

  localparam int DW = VW + FRAC_BITS;   // dividend: magnitude shifted up
  localparam int AW = 2 * VW + 1;       // dot product accumulator

  state_t state, state_next;

  // sequencer counters
  logic [2:0] plane;
  logic [2:0] k;

  // stores
  logic [31:0] matrix [0:15];
  logic [31:0] pst    [0:5][0:3];
  logic [5:0]  plane_mask;

  // working registers
  logic [31:0]          wreg;
  logic signed [VW-1:0] v [0:3];
  logic [SQ_W-1:0]      sumsq;
  logic [LEN_W-1:0]     len;
  logic [31:0]          coef [0:3];
  logic                 degen;
  logic signed [AW-1:0] acc;
  logic                 vis;
  logic signed [31:0]   cx, cy, cz;
  logic [30:0]          rad;

  // handshake helpers
  logic accept;
  logic out_free;
  logic out_load;

  // shared units
  logic signed [VW-1:0]   mul_a, mul_b;
  logic signed [2*VW-1:0] prod;
  logic                   root_start, div_start;
  logic [LEN_W-1:0]       root;
  logic [DW-1:0]          dividend, quo;
  iter_stat_t             sqrt_stat, div_stat;

  // datapath helpers
  logic [3:0]           mat_idx;
  logic [31:0]          mat_word;
  logic [1:0]           widx;
  logic [31:0]          pword;
  logic signed [VW-1:0] vk;
  logic [VW-1:0]        vmag;
  logic [31:0]          qsat;
  logic                 qovf;
  logic signed [32:0]   dsum;
  logic signed [AW-1:0] dterm;
  logic signed [AW-1:0] dot_sum;
  logic                 test_step_done;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  // a new result goes into the output register this cycle
  assign out_load  = out_free && (state == S_EMIT || state == S_RESULT);

  fpc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  fpc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sumsq),
    .root     (root),
    .stat     (sqrt_stat)
  );

  fpc_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (len),
    .quo      (quo),
    .stat     (div_stat)
  );

  // read selects: one matrix word and one plane word per cycle
  always_comb begin
    // even fetch step reads the w row, odd step the row of this axis
    mat_idx  = k[0] ? {k[2:1], plane[2:1]} : {k[2:1], 2'd3};
    mat_word = matrix[mat_idx];
    // first test step reads d, then a, b, c
    widx     = (k == 3'd0) ? 2'd3 : 2'(k - 3'd1);
    pword    = pst[plane][widx];
    vk       = v[k[1:0]];
    vmag     = vk[VW-1] ? VW'(-vk) : VW'(vk);
    dividend = {vmag, {FRAC_BITS{1'b0}}};
    // saturate the quotient to 32 bits with the sign of the component
    qovf     = |quo[DW-1:31];
    if (vk[VW-1]) begin
      qsat = qovf ? INT32_MIN_C : 32'(-quo[31:0]);
    end else begin
      qsat = qovf ? INT32_MAX_C : quo[31:0];
    end
    // (d + radius) scaled up to the product's fixed point
    dsum     = $signed({pword[31], pword}) + $signed({2'b00, rad});
    dterm    = $signed({{(AW - 33){dsum[32]}}, dsum}) <<< FRAC_BITS;
    dot_sum  = acc + $signed({prod[2*VW-1], prod});
    test_step_done = !plane_mask[plane] || (k == 3'd4);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_DERIVE) state_next = S_FETCH;
        else if (accept && op == OP_TEST) state_next = S_TEST;
      end
      S_FETCH: begin
        if (k == 3'd7) state_next = S_SQ;
      end
      S_SQ: begin
        if (k == 3'd3) state_next = S_ROOT_GO;
      end
      S_ROOT_GO: state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (sqrt_stat.done) state_next = (root == '0) ? S_EMIT : S_DIV_GO;
      end
      S_DIV_GO: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_stat.done) state_next = (k == 3'd3) ? S_EMIT : S_DIV_GO;
      end
      S_EMIT: begin
        if (out_free) state_next = (plane == 3'd5) ? S_IDLE : S_FETCH;
      end
      S_TEST: begin
        if (test_step_done && plane == 3'd5) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    item_stall = (state != S_IDLE);
    root_start = (state == S_ROOT_GO);
    div_start  = (state == S_DIV_GO);
    mul_a      = vk;
    mul_b      = vk;
    case (state)
      S_TEST: begin
        case (k)
          3'd1:    mul_a = $signed({cx[31], cx});
          3'd2:    mul_a = $signed({cy[31], cy});
          default: mul_a = $signed({cz[31], cz});
        endcase
        mul_b = $signed({pword[31], pword});
      end
      default: begin
        mul_a = vk;
        mul_b = vk;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters, mask, stores and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      plane        <= '0;
      k            <= '0;
      vis          <= 1'b1;
      plane_mask   <= 6'd15;
      result_valid <= 1'b0;
      for (int i = 0; i < 16; i++) matrix[i] <= '0;
      for (int p = 0; p < 6; p++) begin
        for (int w = 0; w < 4; w++) pst[p][w] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) plane_mask <= cfg_data;
      // held while stalled, loaded when a result is issued
      result_valid <= out_load || (result_valid && result_stall);
      case (state)
        S_IDLE: begin
          plane <= '0;
          k     <= '0;
          vis   <= 1'b1;
          if (accept && op == OP_LOAD) matrix[element_index] <= element_value;
        end
        S_FETCH, S_SQ: begin
          k <= (state_next == state) ? k + 3'd1 : 3'd0;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) k <= k + 3'd1;
        end
        S_EMIT: begin
          if (out_free) begin
            for (int w = 0; w < 4; w++) pst[plane][w] <= coef[w];
            plane <= plane + 3'd1;
            k     <= '0;
          end
        end
        S_TEST: begin
          if (test_step_done) begin
            if (plane_mask[plane] && dot_sum < 0) vis <= 1'b0;
            plane <= plane + 3'd1;
            k     <= '0;
          end else begin
            k <= k + 3'd1;
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cx  <= center_x;
          cy  <= center_y;
          cz  <= center_z;
          rad <= radius;
        end
      end
      S_FETCH: begin
        if (!k[0]) begin
          wreg <= mat_word;
        end else if (plane[0]) begin
          v[k[2:1]] <= $signed({wreg[31], wreg}) + $signed({mat_word[31], mat_word});
        end else begin
          v[k[2:1]] <= $signed({wreg[31], wreg}) - $signed({mat_word[31], mat_word});
        end
      end
      S_SQ: begin
        // product of the previous step arrives in the cycle after issue
        if (k == 3'd0) sumsq <= '0;
        else           sumsq <= sumsq + SQ_W'(prod);
      end
      S_ROOT_WAIT: begin
        if (sqrt_stat.done) begin
          len   <= root;
          degen <= (root == '0);
          for (int w = 0; w < 4; w++) coef[w] <= '0;
        end
      end
      S_DIV_WAIT: begin
        if (div_stat.done) coef[k[1:0]] <= qsat;
      end
      S_EMIT: begin
        if (out_free) begin
          visible     <= 1'b0;
          plane_index <= plane;
          plane_a     <= coef[0];
          plane_b     <= coef[1];
          plane_c     <= coef[2];
          plane_d     <= coef[3];
          degenerate  <= degen;
          last        <= (plane == 3'd5);
        end
      end
      S_TEST: begin
        if (k == 3'd0)                   acc <= dterm;
        else if (k == 3'd2 || k == 3'd3) acc <= dot_sum;
      end
      S_RESULT: begin
        if (out_free) begin
          visible     <= vis;
          plane_index <= '0;
          plane_a     <= '0;
          plane_b     <= '0;
          plane_c     <= '0;
          plane_d     <= '0;
          degenerate  <= 1'b0;
          last        <= 1'b1;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // a zeroed plane goes out with all four coefficients zero
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |->
      plane_a == 0 && plane_b == 0 && plane_c == 0 && plane_d == 0)
    else $error("degenerate plane with non-zero coefficients");

  // a result that is not the last one only appears mid-derivation
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> state != S_IDLE && state != S_TEST)
    else $error("intermediate result outside plane derivation");

  // the root and the divider never run at once
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.busy |-> !div_stat.busy)
    else $error("square root and divider busy together");

  // in S_EMIT with the output register free, the plane result is loaded into it
  a_emit_advances: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> result_valid)
    else $error("plane result not loaded");

endmodule

`default_nettype wire

>>> src/fpc_mul.sv
// shared signed multiplier with a registered product
// depends on fpc_pkg for the component width
`timescale 1ns / 1ps
`default_nettype none

module fpc_mul (
  input  wire logic                           clk,
  input  wire logic signed [fpc_pkg::VW-1:0]  mul_a,
  input  wire logic signed [fpc_pkg::VW-1:0]  mul_b,
  output logic signed [2*fpc_pkg::VW-1:0]     prod
);
  import fpc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

`default_nettype wire

>>> src/fpc_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
// depends on fpc_pkg for widths and the status struct
`timescale 1ns / 1ps
`default_nettype none

module fpc_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [fpc_pkg::SQ_W-1:0]      radicand,
  output logic [fpc_pkg::LEN_W-1:0]          root,
  output fpc_pkg::iter_stat_t                stat
);
  import fpc_pkg::*;

  localparam int RW = 2 * LEN_W;       // radicand padded to whole bit pairs
  localparam int MW = LEN_W + 3;       // partial remainder width
  localparam int CW = $clog2(LEN_W + 1);

  logic [RW-1:0] rad;
  logic [MW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [MW-1:0] r2;
  logic [MW-1:0] trial;

  assign r2    = {rem[MW-3:0], rad[RW-1:RW-2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= CW'(LEN_W);
    end else if (stat.busy) begin
      cnt       <= cnt - 1'b1;
      stat.busy <= (cnt != CW'(1));
      stat.done <= (cnt == CW'(1));
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {{(RW - SQ_W){1'b0}}, radicand};
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      rad <= {rad[RW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root[LEN_W-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[LEN_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> src/fpc_div.sv
// restoring divider, one quotient bit per cycle
// depends on fpc_pkg for the divisor width and the status struct
`timescale 1ns / 1ps
`default_nettype none

module fpc_div #(
  parameter int DW = 49
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [DW-1:0]              dividend,
  input  wire logic [fpc_pkg::LEN_W-1:0]  divisor,
  output logic [DW-1:0]                   quo,
  output fpc_pkg::iter_stat_t             stat
);
  import fpc_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   t;
  logic [CW-1:0]    cnt;

  assign t = {rem, quo[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= CW'(DW);
    end else if (stat.busy) begin
      cnt       <= cnt - 1'b1;
      stat.busy <= (cnt != CW'(1));
      stat.done <= (cnt == CW'(1));
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (stat.busy) begin
      if (t >= {1'b0, divisor}) begin
        rem <= LEN_W'(t - {1'b0, divisor});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= t[LEN_W-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/frustum_plane_sphere_cull_unit_tb.sv
// testbench for the frustum plane extraction and sphere cull unit
// depends on fpc_pkg and frustum_plane_sphere_cull_unit; self-checking, no files
`timescale 1ns / 1ps

module frustum_plane_sphere_cull_unit_tb;
  import fpc_pkg::*;

  localparam int FRAC = 16;
  localparam logic [1:0] OP_NONE = 2'd3;   // unused op, ignored by the unit

  // one expected result item
  typedef struct packed {
    logic        visible;
    logic [2:0]  plane_index;
    logic [31:0] plane_a, plane_b, plane_c, plane_d;
    logic        degenerate;
    logic        last;
  } cull_result_t;

  // predictor of the unit plus the queue of results it still owes
  class cull_scoreboard;
    logic [31:0]  matrix [16];
    logic [31:0]  planes [6][4];
    logic [5:0]   mask;
    cull_result_t owed [$];
    int           mismatches;
    int           checked;
    int           n_degen;
    int           n_visible;

    function void clear();
      foreach (matrix[i]) matrix[i] = '0;
      foreach (planes[p, k]) planes[p][k] = '0;
      mask = 6'd15;
    endfunction

    // coefficient times 2^FRAC over the length, toward zero, saturated
    function logic [31:0] scale_coef(logic signed [33:0] x, logic [33:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = x < 0 ? 64'(-x) : 64'(x);
      q = (mag << FRAC) / len;
      if (x < 0) return q >= 64'h8000_0000 ? INT32_MIN_C : 32'(-q);
      return q > 64'h7fff_ffff ? INT32_MAX_C : q[31:0];
    endfunction

    function logic [33:0] root_of(logic [65:0] s);
      logic [33:0]  r;
      logic [33:0]  c;
      logic [67:0]  sq;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (34'd1 << b);
        sq = 68'(c) * 68'(c);
        if (sq <= 68'(s)) r = c;
      end
      return r;
    endfunction

    function void derive();
      logic signed [33:0] v [4];
      logic signed [33:0] w, e;
      logic [65:0] s;
      logic [33:0] len;
      cull_result_t r;
      int p;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          p = 2 * i + j;
          for (int k = 0; k < 4; k++) begin
            w = 34'(signed'(matrix[k * 4 + 3]));
            e = 34'(signed'(matrix[k * 4 + i]));
            v[k] = j ? w + e : w - e;
          end
          s = '0;
          for (int k = 0; k < 3; k++) s += 66'(v[k]) * 66'(v[k]);
          len = root_of(s);
          for (int k = 0; k < 4; k++)
            planes[p][k] = len == 0 ? 32'd0 : scale_coef(v[k], len);
          r.visible = 1'b0;
          r.plane_index = 3'(p);
          r.plane_a = planes[p][0];
          r.plane_b = planes[p][1];
          r.plane_c = planes[p][2];
          r.plane_d = planes[p][3];
          r.degenerate = len == 0;
          r.last = p == 5;
          owed = {owed, r};
        end
      end
    endfunction

    function logic sphere_passes(logic [31:0] cx, cy, cz, logic [30:0] rad);
      logic signed [79:0] s;
      for (int p = 0; p < 6; p++) begin
        if (!mask[p]) continue;
        s = 80'(signed'(cx)) * 80'(signed'(planes[p][0]))
          + 80'(signed'(cy)) * 80'(signed'(planes[p][1]))
          + 80'(signed'(cz)) * 80'(signed'(planes[p][2]))
          + ((80'(signed'(planes[p][3])) + 80'(rad)) <<< FRAC);
        if (s < 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [1:0] o, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] cx, cy, cz, logic [30:0] rad);
      cull_result_t r;
      case (o)
        OP_LOAD: matrix[idx] = val;
        OP_DERIVE: derive();
        OP_TEST: begin
          r = '{default: '0};
          r.visible = sphere_passes(cx, cy, cz, rad);
          r.last = 1'b1;
          owed = {owed, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(cull_result_t got);
      cull_result_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $time);
        return;
      end
      want = owed.pop_front();
      if (got.degenerate) n_degen++;
      if (got.visible) n_visible++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: want v%0b p%0d %h %h %h %h dg%0b l%0b",
            $time, want.visible, want.plane_index, want.plane_a, want.plane_b,
            want.plane_c, want.plane_d, want.degenerate, want.last);
          $display("  got v%0b p%0d %h %h %h %h dg%0b l%0b",
            got.visible, got.plane_index, got.plane_a, got.plane_b,
            got.plane_c, got.plane_d, got.degenerate, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] op = '0;
  logic [3:0] element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
  logic [30:0] radius = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic visible, degenerate, last;
  logic [2:0] plane_index;
  logic signed [31:0] plane_a, plane_b, plane_c, plane_d;

  cull_scoreboard sb;
  bit calm;       // last part of the run: no idling on either side
  int items_sent;

  always #4 clk = ~clk;

  frustum_plane_sphere_cull_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .op(op),
    .element_index(element_index), .element_value(element_value),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .radius(radius),
    .result_valid(result_valid), .result_stall(result_stall),
    .visible(visible), .plane_index(plane_index),
    .plane_a(plane_a), .plane_b(plane_b), .plane_c(plane_c), .plane_d(plane_d),
    .degenerate(degenerate), .last(last)
  );

  // result side: sample at the edge, stall in random bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        sb.check_result('{visible, plane_index, plane_a, plane_b, plane_c,
                          plane_d, degenerate, last});
    end
  end

  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        result_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  // send one item, with a random gap in front of it; valid stays up after
  // the accepting edge so that the next item can follow straight on
  task automatic send_item(logic [1:0] o, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] cx, cy, cz, logic [30:0] rad);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    element_index <= idx;
    element_value <= val;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    radius <= rad;
    do @(posedge clk); while (item_stall);
    sb.note_item(o, idx, val, cx, cy, cz, rad);
    items_sent++;
  endtask

  task automatic load(logic [3:0] idx, logic [31:0] val);
    send_item(OP_LOAD, idx, val, '0, '0, '0, '0);
  endtask

  task automatic test_sphere(logic [31:0] cx, cy, cz, logic [30:0] rad);
    send_item(OP_TEST, '0, '0, cx, cy, cz, rad);
  endtask

  // mask write only once the unit has drained
  task automatic write_mask(logic [5:0] m);
    item_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.mask = m;
    cfg_valid <= 1'b0;
  endtask

  // random signed Q16.16 value, mostly modest, sometimes extreme
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return 32'(signed'($urandom_range(0, 8)) - 4) <<< FRAC;
      default: return 32'(signed'(32'($urandom_range(0, 32'h0006_0000))) - 32'h0003_0000);
    endcase
  endfunction

  function automatic logic [30:0] pick_radius();
    case ($urandom_range(0, 5))
      0: return 31'h7fff_ffff;
      1: return '0;
      2: return 31'($urandom());
      default: return 31'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  initial begin
    int frames;
    logic [31:0] ext;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: degenerate planes from the zeroed matrix, empty store tests
    test_sphere('0, '0, '0, '0);
    send_item(OP_DERIVE, '0, '0, '0, '0, '0, '0);
    send_item(OP_NONE, 4'hf, 32'hffff_ffff, '1, '1, '1, '1);   // ignored
    // identity matrix, then planes and spheres on both sides
    for (int i = 0; i < 16; i++)
      load(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    send_item(OP_DERIVE, '0, '0, '0, '0, '0, '0);
    test_sphere('0, '0, '0, 31'h0001_0000);
    test_sphere(32'h0005_0000, '0, '0, 31'h0000_8000);
    test_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    test_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '0);
    // extreme elements so that d saturates
    load(4'd3, 32'h0000_0001);
    load(4'd15, 32'h7fff_ffff);
    load(4'd12, 32'h8000_0000);
    load(4'd0, 32'h7fff_ffff);
    send_item(OP_DERIVE, '0, '0, '0, '0, '0, '0);
    write_mask(6'd0);                      // empty mask: always visible
    test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    write_mask(6'd63);
    test_sphere(32'h7fff_ffff, '0, 32'h8000_0000, 31'h7fff_ffff);

    // random frames: load a whole matrix, derive, then a run of sphere tests
    frames = 0;
    while (items_sent < 460) begin
      if (frames % 4 == 3) write_mask(frames % 8 == 3 ? 6'd63 : 6'($urandom()));
      if (items_sent > 400) calm = 1'b1;
      for (int i = 0; i < 16; i++)
        if ($urandom_range(0, 3) != 0) load(4'(i), pick_value());
      if ($urandom_range(0, 9) == 0) load(4'($urandom()), '0);
      if ($urandom_range(0, 12) == 0) begin
        // zero the xyz of row 3 and rows x/y/z so every normal vanishes
        for (int i = 0; i < 12; i++) load(4'(i), '0);
      end
      send_item(OP_DERIVE, '0, '0, '0, '0, '0, '0);
      repeat ($urandom_range(4, 14)) begin
        if ($urandom_range(0, 15) == 0) begin
          ext = $urandom();
          send_item(OP_NONE, 4'(ext), ext, ext, ~ext, ext, 31'(ext));
        end
        test_sphere(pick_value(), pick_value(), pick_value(), pick_radius());
      end
      frames++;
    end
    write_mask(6'd15);
    test_sphere('0, '0, '0, '0);
    item_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d input items over %0d frames, %0d result items checked",
             items_sent, frames, sb.checked);
    $display("%0d degenerate planes, %0d visible flags seen",
             sb.n_degen, sb.n_visible);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: stops a run that hangs
  initial begin
    #40_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/fpc_pkg.sv
src/fpc_mul.sv
src/fpc_sqrt.sv
src/fpc_div.sv
src/frustum_plane_sphere_cull_unit.sv
tb/sv/frustum_plane_sphere_cull_unit_tb.sv
